[hdl/first_fit_page_allocator_core_defines.svh]
// Assertion macros shared by the allocator RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFPA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFPA_ASSERT(lbl, clk, rst, prop, msg)
`define FFPA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hdl/ffpa_pkg.sv]
// Types and constants of the first-fit page allocator.
// No dependencies; used by the interfaces and the allocator core.
`default_nettype none

package ffpa_pkg;

  localparam int ADDR_W   = 32;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 3;
  localparam int MARK_W   = 3;

  // page map entry bits
  localparam int MARK_ALLOC_BIT = 0;
  localparam int MARK_START_BIT = 1;
  localparam int MARK_USER_BIT  = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOSTART = 3'd4;

  localparam logic CFG_USABLE_PAGES = 1'b0;
  localparam logic CFG_BASE_ADDRESS = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_SCAN,
    S_A_WRITE,
    S_F_CHECK,
    S_F_START,
    S_F_WALK,
    S_DONE
  } ffpa_state_t;

endpackage

`default_nettype wire

[hdl/ffpa_req_if.sv]
// Request channel of the page allocator: valid/ready plus request fields.
// Depends on ffpa_pkg.
`default_nettype none

interface ffpa_req_if
  import ffpa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               command;
  logic [COUNT_W-1:0] page_count;
  logic               user_mark;
  logic [ADDR_W-1:0]  free_address;

  modport source (output valid, command, page_count, user_mark, free_address,
                  input ready);
  modport sink   (input valid, command, page_count, user_mark, free_address,
                  output ready);
endinterface

`default_nettype wire

[hdl/ffpa_rsp_if.sv]
// Response channel of the page allocator: valid/ready plus status and address.
// Depends on ffpa_pkg.
`default_nettype none

interface ffpa_rsp_if
  import ffpa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   block_address;

  modport source (output valid, status, block_address, input ready);
  modport sink   (input valid, status, block_address, output ready);
endinterface

`default_nettype wire

[hdl/ffpa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/first_fit_page_allocator_core.sv]
// First-fit contiguous page allocator. After reset the page map is cleared one
// entry a cycle, during which no request is taken (config writes still are).
// Everything goes through the single read port of the page map RAM, one entry
// per cycle. An allocate scans pages up to the end of the fitting run (at most
// the usable page count) and then marks the pages of the block; a zero count
// answers without a scan. A free clears the pages of the block. One request is
// in work at a time; the next is taken while the previous response waits in
// the output register.
`default_nettype none
`include "first_fit_page_allocator_core_defines.svh"

module first_fit_page_allocator_core
  import ffpa_pkg::*;
#(
  parameter int MAX_PAGES  = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data,
  ffpa_req_if.sink               req,
  ffpa_rsp_if.source             rsp
);

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int LW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  ffpa_state_t state, state_next;

  logic [COUNT_W-1:0]  usable_pages;
  logic [ADDR_W-1:0]   base_address;
  logic [LW-1:0]       usable_ext, live;

  logic                cmd_q, user_q;
  logic                cmd_q_next, user_q_next;
  logic [COUNT_W-1:0]  count_q, count_q_next;
  logic [ADDR_W-1:0]   addr_q, addr_q_next;

  logic [CNT_W-1:0]    rd_idx, rd_idx_next;
  logic                rd_pend, rd_pend_next;
  logic [IDX_W-1:0]    chk_idx, chk_idx_next;
  logic [CNT_W-1:0]    run, run_next, run_inc;
  logic [IDX_W-1:0]    wr_idx, wr_idx_next;
  logic [IDX_W-1:0]    wr_end, wr_end_next;
  logic [IDX_W-1:0]    first_pg, first_pg_next;
  logic [IDX_W-1:0]    clr_idx, clr_idx_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [ADDR_W-1:0]   res_addr, res_addr_next;

  logic                out_valid, out_valid_next;
  logic [STATUS_W-1:0] out_status, out_status_next;
  logic [ADDR_W-1:0]   out_addr, out_addr_next;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  logic [MARK_W-1:0]   mem_wdata, mem_rdata;

  logic                req_fire, hit, rd_more, walk_more, below, in_range;
  logic [LW-1:0]       chk_nxt, hit_first;
  logic [ADDR_W-1:0]   diff, page_full;

  ffpa_ram #(
    .WIDTH (MARK_W),
    .DEPTH (MAX_PAGES)
  ) u_page_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign usable_ext = LW'(usable_pages);
  assign live       = (usable_ext < LW'(MAX_PAGES)) ? usable_ext : LW'(MAX_PAGES);

  assign req.ready     = (state == S_IDLE);
  assign req_fire      = req.valid && req.ready;
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.block_address = out_addr;

  // scan datapath
  assign run_inc   = (mem_rdata == '0) ? run + CNT_W'(1) : '0;
  assign hit       = rd_pend && (LW'(run_inc) == LW'(count_q));
  assign hit_first = LW'(chk_idx) + LW'(1) - LW'(count_q);
  assign rd_more   = LW'(rd_idx) < live;
  assign chk_nxt   = LW'(chk_idx) + LW'(1);
  assign walk_more = chk_nxt < live;

  // free address check
  assign below     = addr_q < base_address;
  assign diff      = addr_q - base_address;
  assign page_full = diff >> PAGE_SHIFT;
  assign in_range  = !below && (page_full < ADDR_W'(live));

  always_comb begin
    state_next      = state;
    cmd_q_next      = cmd_q;
    user_q_next     = user_q;
    count_q_next    = count_q;
    addr_q_next     = addr_q;
    rd_idx_next     = rd_idx;
    rd_pend_next    = rd_pend;
    chk_idx_next    = chk_idx;
    run_next        = run;
    wr_idx_next     = wr_idx;
    wr_end_next     = wr_end;
    first_pg_next   = first_pg;
    clr_idx_next    = clr_idx;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_addr_next   = out_addr;
    mem_we          = 1'b0;
    mem_waddr       = wr_idx;
    mem_wdata       = '0;
    mem_raddr       = chk_idx;

    unique case (state)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx;
        clr_idx_next = clr_idx + IDX_W'(1);
        if (clr_idx == IDX_W'(MAX_PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_fire) begin
          cmd_q_next    = req.command;
          user_q_next   = req.user_mark;
          count_q_next  = req.page_count;
          addr_q_next   = req.free_address;
          res_addr_next = '0;
          if (req.command == CMD_ALLOC) begin
            if (req.page_count == '0) begin
              res_status_next = STAT_ZERO;
              state_next      = S_DONE;
            end else begin
              rd_idx_next  = '0;
              rd_pend_next = 1'b0;
              run_next     = '0;
              state_next   = S_A_SCAN;
            end
          end else begin
            state_next = S_F_CHECK;
          end
        end
      end

      // reads run one entry ahead of the run counter
      S_A_SCAN: begin
        if (rd_pend) begin
          run_next = run_inc;
        end
        if (hit) begin
          wr_idx_next   = hit_first[IDX_W-1:0];
          first_pg_next = hit_first[IDX_W-1:0];
          wr_end_next   = chk_idx;
          rd_pend_next  = 1'b0;
          state_next    = S_A_WRITE;
        end else if (rd_more) begin
          mem_raddr    = rd_idx[IDX_W-1:0];
          chk_idx_next = rd_idx[IDX_W-1:0];
          rd_pend_next = 1'b1;
          rd_idx_next  = rd_idx + CNT_W'(1);
        end else begin
          rd_pend_next = 1'b0;
          if (!rd_pend) begin
            res_status_next = STAT_NOFIT;
            state_next      = S_DONE;
          end
        end
      end

      S_A_WRITE: begin
        mem_we                    = 1'b1;
        mem_waddr                 = wr_idx;
        mem_wdata[MARK_ALLOC_BIT] = 1'b1;
        mem_wdata[MARK_START_BIT] = (wr_idx == first_pg);
        mem_wdata[MARK_USER_BIT]  = user_q;
        wr_idx_next               = wr_idx + IDX_W'(1);
        if (wr_idx == wr_end) begin
          res_status_next = STAT_OK;
          res_addr_next   = base_address + (ADDR_W'(first_pg) << PAGE_SHIFT);
          state_next      = S_DONE;
        end
      end

      S_F_CHECK: begin
        if (!in_range) begin
          res_status_next = STAT_RANGE;
          state_next      = S_DONE;
        end else begin
          mem_raddr    = page_full[IDX_W-1:0];
          chk_idx_next = page_full[IDX_W-1:0];
          state_next   = S_F_START;
        end
      end

      S_F_START: begin
        if (!mem_rdata[MARK_START_BIT]) begin
          res_status_next = STAT_NOSTART;
          state_next      = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx;
          if (walk_more) begin
            mem_raddr    = chk_nxt[IDX_W-1:0];
            chk_idx_next = chk_nxt[IDX_W-1:0];
            state_next   = S_F_WALK;
          end else begin
            res_status_next = STAT_OK;
            state_next      = S_DONE;
          end
        end
      end

      // clear the tail of the block; the read of the next page never hits
      // the entry being written
      S_F_WALK: begin
        if (mem_rdata == '0 || mem_rdata[MARK_START_BIT]) begin
          res_status_next = STAT_OK;
          state_next      = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx;
          if (walk_more) begin
            mem_raddr    = chk_nxt[IDX_W-1:0];
            chk_idx_next = chk_nxt[IDX_W-1:0];
          end else begin
            res_status_next = STAT_OK;
            state_next      = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_addr_next   = res_addr;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q      <= cmd_q_next;
    user_q     <= user_q_next;
    count_q    <= count_q_next;
    addr_q     <= addr_q_next;
    rd_idx     <= rd_idx_next;
    chk_idx    <= chk_idx_next;
    run        <= run_next;
    wr_idx     <= wr_idx_next;
    wr_end     <= wr_end_next;
    first_pg   <= first_pg_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    out_status <= out_status_next;
    out_addr   <= out_addr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_pages <= COUNT_W'(256);
      base_address <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_USABLE_PAGES: usable_pages <= cfg_data[COUNT_W-1:0];
        CFG_BASE_ADDRESS: base_address <= cfg_data;
        default:          usable_pages <= usable_pages;
      endcase
    end
  end

  `FFPA_ASSERT(a_idle_no_write, clk, rst, (state == S_IDLE) |-> !mem_we, "map write while idle")
  `FFPA_ASSERT(a_one_at_a_time, clk, rst, req_fire |=> !req.ready, "second request taken while busy")
  `FFPA_ASSERT(a_fail_addr_zero, clk, rst, (rsp.valid && rsp.status != STAT_OK) |-> (rsp.block_address == '0), "failed response carries an address")
  `FFPA_ASSERT(a_write_in_range, clk, rst, (state == S_A_WRITE) |-> (LW'(wr_idx) < live), "allocation writes beyond the usable pages")
  `FFPA_ASSERT(a_free_cmd, clk, rst, (state == S_F_START || state == S_F_WALK) |-> (cmd_q == CMD_FREE), "free walk entered for an allocate")

endmodule

`default_nettype wire
